[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/core/hct_pkg.sv]
`default_nettype none

package hct_pkg;

   localparam int MAX_GRID_SIDE = 4096;

   localparam int COORD_W  = 12;
   localparam int GRID_W   = 13;
   localparam int HGT_W    = 8;
   localparam int SCALE_W  = 16;
   localparam int STEP_W   = 17;
   localparam int POSY_W   = 28;
   localparam int NRM_W    = 16;
   localparam int DELTA_W  = 19;
   localparam int CROSS_W  = 11;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_SCALE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_SCALE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_U_STEP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_V_STEP      = 3'd5;

   // Normal datapath widths.
   localparam int MAG_W    = 25;
   localparam int SUM_W    = 52;
   localparam int LEN_W    = 26;
   localparam int SQREM_W  = 28;
   localparam int QUO_W    = 15;
   localparam int DREM_W   = 26;
   localparam int NRM_ONE  = 16384;
   localparam int TEX_ONE  = 65536;

   localparam int SQ_PER_STAGE  = 2;
   localparam int SQ_STAGES     = LEN_W / SQ_PER_STAGE;
   localparam int DIV_PER_STAGE = 3;
   localparam int DIV_STAGES    = QUO_W / DIV_PER_STAGE + 1;
   localparam int SIDE_DEPTH    = SQ_STAGES + DIV_STAGES;

   localparam logic [2:0] SLOT_LAST = 3'd5;

   typedef struct packed {
      logic [COORD_W-1:0] cell_column;
      logic [COORD_W-1:0] cell_row;
      logic [HGT_W-1:0]   height_near_left;
      logic [HGT_W-1:0]   height_near_right;
      logic [HGT_W-1:0]   height_far_left;
      logic [HGT_W-1:0]   height_far_right;
   } req_type;

   typedef struct packed {
      logic signed [31:0]    pos_x;
      logic [POSY_W-1:0]     pos_y;
      logic signed [31:0]    pos_z;
      logic [STEP_W-1:0]     tex_u;
      logic [STEP_W-1:0]     tex_v;
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
      logic                  last_vertex;
   } rsp_type;

   // One vertex as issued by the sequencer.
   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dz;
      logic [GRID_W-1:0]         vc;
      logic [GRID_W-1:0]         vr;
      logic [HGT_W-1:0]          h;
      logic signed [CROSS_W-1:0] p;
      logic signed [CROSS_W-1:0] q;
      logic signed [CROSS_W-1:0] r;
      logic                      last;
   } beat_type;

   // Per-vertex data that rides alongside the normal calculation.
   typedef struct packed {
      logic signed [31:0]    pos_x;
      logic [POSY_W-1:0]     pos_y;
      logic signed [31:0]    pos_z;
      logic [STEP_W-1:0]     tex_u;
      logic [STEP_W-1:0]     tex_v;
      logic                  last;
      logic                  zero;
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
   } side_type;

   typedef struct packed {
      logic [SQREM_W-1:0] rem;
      logic [LEN_W-1:0]   root;
   } sq_type;

   // Corner of each output slot, for the four parity cases (row, column).
   function automatic logic [1:0] slot_corner(input logic [1:0] parity,
                                              input logic [2:0] slot);
      logic [1:0] c;
      c = 2'd0;
      case ({parity, slot})
         5'b00_000: c = 2'd1;
         5'b00_001: c = 2'd0;
         5'b00_010: c = 2'd2;
         5'b00_011: c = 2'd3;
         5'b00_100: c = 2'd1;
         5'b00_101: c = 2'd2;
         5'b01_000: c = 2'd3;
         5'b01_001: c = 2'd0;
         5'b01_010: c = 2'd2;
         5'b01_011: c = 2'd1;
         5'b01_100: c = 2'd0;
         5'b01_101: c = 2'd3;
         5'b10_000: c = 2'd1;
         5'b10_001: c = 2'd0;
         5'b10_010: c = 2'd3;
         5'b10_011: c = 2'd3;
         5'b10_100: c = 2'd0;
         5'b10_101: c = 2'd2;
         5'b11_000: c = 2'd3;
         5'b11_001: c = 2'd1;
         5'b11_010: c = 2'd2;
         5'b11_011: c = 2'd1;
         5'b11_100: c = 2'd0;
         5'b11_101: c = 2'd2;
         default:   c = 2'd0;
      endcase
      return c;
   endfunction

   // Digit-by-digit square root: a few result bits per call.
   function automatic sq_type sqrt_step(input sq_type cur,
                                        input logic [2*SQ_PER_STAGE-1:0] bits);
      sq_type nxt;
      logic [SQREM_W-1:0] rem2;
      logic [SQREM_W-1:0] trial;
      nxt = cur;
      for (int i = 0; i < SQ_PER_STAGE; i++) begin
         rem2  = {nxt.rem[SQREM_W-3:0], bits[2*(SQ_PER_STAGE-1-i) +: 2]};
         trial = {nxt.root[SQREM_W-3:0], 2'b01};
         if (rem2 >= trial) begin
            nxt.rem  = rem2 - trial;
            nxt.root = {nxt.root[LEN_W-2:0], 1'b1};
         end else begin
            nxt.rem  = rem2;
            nxt.root = {nxt.root[LEN_W-2:0], 1'b0};
         end
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

[rtl/core/heightmap_cell_triangulator.sv]
`default_nettype none
// Channel   Direction  Handshake              Beat
// req_      in         req_valid / req_stall  one grid cell (req_type)
// rsp_      out        rsp_valid / rsp_stall  one vertex (rsp_type)
// csr_      in         csr_we                 register write, index and data
//
// Each cell gives six vertex beats, one per unstalled cycle, and holds the
// sequencer until its sixth beat moves on; the vertex pipeline takes one beat
// per unstalled cycle. A cell passes the sequencer, five geometry stages,
// 13 square-root stages, six divider stages and the output register.
// Reset is synchronous; it clears the valid bits and the slot counter and loads the CSR defaults.
// A stall at the output freezes the whole pipeline in place; no beat is lost.
`include "assert_macros.svh"

module heightmap_cell_triangulator (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  hct_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output hct_pkg::rsp_type                 rsp_data,
   input  wire                              csr_we,
   input  wire [hct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [hct_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hct_pkg::*;

   localparam logic signed [35:0] S32_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] S32_MIN = -36'sh0_8000_0000;

   // Configuration registers.
   logic [GRID_W-1:0]  gwidth_ff, gheight_ff;
   logic [SCALE_W-1:0] hscale_ff, vscale_ff;
   logic [STEP_W-1:0]  ustep_ff, vstep_ff;
   logic [GRID_W-1:0]  gside_in;

   assign gside_in = (csr_wdata[GRID_W-1:0] > GRID_W'(MAX_GRID_SIDE))
                     ? GRID_W'(MAX_GRID_SIDE) : csr_wdata[GRID_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         gwidth_ff  <= GRID_W'(512);
         gheight_ff <= GRID_W'(512);
         hscale_ff  <= SCALE_W'(2048);
         vscale_ff  <= SCALE_W'(410);
         ustep_ff   <= STEP_W'(128);
         vstep_ff   <= STEP_W'(128);
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  gwidth_ff  <= gside_in;
            CSR_GRID_HEIGHT: gheight_ff <= gside_in;
            CSR_HORIZ_SCALE: hscale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_VERT_SCALE:  vscale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_U_STEP:      ustep_ff   <= csr_wdata;
            CSR_V_STEP:      vstep_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves when the output register can take a beat.
   logic adv;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_vld_ff;

   assign adv = !rsp_vld_ff || !rsp_stall;

   beat_type beat;
   logic     beat_valid;

   hct_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .grid_width  (gwidth_ff),
      .grid_height (gheight_ff),
      .beat        (beat),
      .beat_valid  (beat_valid)
   );

   function automatic logic signed [31:0] sat_s32(input logic signed [35:0] v);
      logic signed [31:0] s;
      if (v > S32_MAX) begin
         s = S32_MAX[31:0];
      end else if (v < S32_MIN) begin
         s = S32_MIN[31:0];
      end else begin
         s = v[31:0];
      end
      return s;
   endfunction

   function automatic logic [STEP_W-1:0] sat_tex(input logic [29:0] v);
      return (v > 30'(TEX_ONE)) ? STEP_W'(TEX_ONE) : v[STEP_W-1:0];
   endfunction

   // Stage 1: products for position, texture and cross product.
   logic               v1_ff;
   logic signed [35:0] s1_px_ff, s1_pz_ff;
   logic [23:0]        s1_py_ff, py_prod;
   logic [29:0]        s1_tu_ff, s1_tv_ff, tu_prod, tv_prod;
   logic signed [27:0] s1_c_ff [3];
   logic               s1_hzero_ff, s1_last_ff;

   assign py_prod = beat.h * vscale_ff;
   assign tu_prod = beat.vc * ustep_ff;
   assign tv_prod = beat.vr * vstep_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff    <= $signed({1'b0, hscale_ff}) * beat.dx;
         s1_pz_ff    <= $signed({1'b0, hscale_ff}) * beat.dz;
         s1_py_ff    <= py_prod;
         s1_tu_ff    <= tu_prod;
         s1_tv_ff    <= tv_prod;
         s1_c_ff[0]  <= $signed({1'b0, vscale_ff}) * beat.p;
         s1_c_ff[1]  <= $signed({1'b0, hscale_ff}) * beat.q;
         s1_c_ff[2]  <= $signed({1'b0, vscale_ff}) * beat.r;
         s1_hzero_ff <= (hscale_ff == '0);
         s1_last_ff  <= beat.last;
      end
   end

   // Stage 2: saturation, magnitudes and the degenerate-triangle flag.
   logic     v2_ff;
   side_type s2_ff, s2_in;

   always_comb begin
      s2_in       = '0;
      s2_in.pos_x = sat_s32(s1_px_ff);
      s2_in.pos_y = {s1_py_ff, 4'b0000};
      s2_in.pos_z = sat_s32(s1_pz_ff);
      s2_in.tex_u = sat_tex(s1_tu_ff);
      s2_in.tex_v = sat_tex(s1_tv_ff);
      s2_in.last  = s1_last_ff;
      for (int j = 0; j < 3; j++) begin
         s2_in.neg[j] = s1_c_ff[j][27];
         s2_in.mag[j] = s1_c_ff[j][27] ? MAG_W'(-s1_c_ff[j]) : MAG_W'(s1_c_ff[j]);
      end
      s2_in.zero = s1_hzero_ff || (s2_in.mag == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= s2_in;
      end
   end

   // Stage 3: shift all three up until the largest reaches bit 24.
   logic             v3_ff;
   side_type         s3_ff, s3_in;
   logic [MAG_W-1:0] mx;
   logic [4:0]       sh;

   always_comb begin
      mx = s2_ff.mag[0];
      if (s2_ff.mag[1] > mx) mx = s2_ff.mag[1];
      if (s2_ff.mag[2] > mx) mx = s2_ff.mag[2];
      sh = 5'd0;
      for (int i = 0; i < MAG_W; i++) begin
         if (mx[i]) begin
            sh = 5'(MAG_W - 1 - i);
         end
      end
      s3_in = s2_ff;
      for (int j = 0; j < 3; j++) begin
         s3_in.mag[j] = s2_ff.mag[j] << sh;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff <= s3_in;
      end
   end

   // Stage 4: squares.  Stage 5: their sum.
   logic                 v4_ff, v5_ff;
   side_type             s4_ff, s5_ff;
   logic [2*MAG_W-1:0]   sq_ff [3];
   logic [SUM_W-1:0]     sum_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ff <= s3_ff;
         for (int j = 0; j < 3; j++) begin
            sq_ff[j] <= s3_ff.mag[j] * s3_ff.mag[j];
         end
         s5_ff  <= s4_ff;
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      end
   end

   // Length, then the three rounded quotients.
   logic [LEN_W-1:0]       len;
   logic [2:0][QUO_W-1:0]  quo;
   side_type               side_ff [SIDE_DEPTH];
   logic                   vld_ff  [SIDE_DEPTH];

   hct_sqrt u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .radicand (sum_ff),
      .root     (len)
   );

   hct_div u_div (
      .clock (clock),
      .adv   (adv),
      .mag   (side_ff[SQ_STAGES-1].mag),
      .len   (len),
      .quo   (quo)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= s5_ff;
         for (int k = 1; k < SIDE_DEPTH; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Output stage: clamp, sign and zero forcing.
   side_type              sd;
   logic [NRM_W-1:0]      nmag [3];
   logic signed [NRM_W-1:0] nval [3];

   assign sd = side_ff[SIDE_DEPTH-1];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         nmag[j] = (quo[j] > QUO_W'(NRM_ONE)) ? NRM_W'(NRM_ONE) : NRM_W'(quo[j]);
         if (sd.zero) begin
            nval[j] = '0;
         end else if (sd.neg[j]) begin
            nval[j] = -$signed(nmag[j]);
         end else begin
            nval[j] = $signed(nmag[j]);
         end
      end
      rsp_in.pos_x       = sd.pos_x;
      rsp_in.pos_y       = sd.pos_y;
      rsp_in.pos_z       = sd.pos_z;
      rsp_in.tex_u       = sd.tex_u;
      rsp_in.tex_v       = sd.tex_v;
      rsp_in.normal_x    = nval[0];
      rsp_in.normal_y    = nval[1];
      rsp_in.normal_z    = nval[2];
      rsp_in.last_vertex = sd.last;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         v5_ff      <= 1'b0;
         for (int k = 0; k < SIDE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         v1_ff     <= beat_valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         v5_ff     <= v4_ff;
         vld_ff[0] <= v5_ff;
         for (int k = 1; k < SIDE_DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_vld_ff <= vld_ff[SIDE_DEPTH-1];
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // A fresh cell keeps the sequencer busy for the following cycle.
   `ASSERT_CLK(a_cell_busy, clock, reset, (req_valid && !req_stall) |=> req_stall, "cell not held")
   // Normals stay within one in Q1.14.
   `ASSERT_NEVER(a_nrm_range, clock, reset, rsp_valid && (rsp_data.normal_x > 16'sd16384 || rsp_data.normal_x < -16'sd16384 || rsp_data.normal_y > 16'sd16384 || rsp_data.normal_y < -16'sd16384 || rsp_data.normal_z > 16'sd16384 || rsp_data.normal_z < -16'sd16384), "normal out of range")
   // Texture coordinates never pass one.
   `ASSERT_NEVER(a_tex_range, clock, reset, rsp_valid && (rsp_data.tex_u > 17'd65536 || rsp_data.tex_v > 17'd65536), "texture out of range")

endmodule

`default_nettype wire

[rtl/core/hct_seq.sv]
`default_nettype none

// Holds one cell and issues its six vertices, one per advancing cycle.
module hct_seq (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         adv,
   input  wire                         req_valid,
   input  hct_pkg::req_type            req_data,
   output logic                        req_stall,
   input  wire [hct_pkg::GRID_W-1:0]   grid_width,
   input  wire [hct_pkg::GRID_W-1:0]   grid_height,
   output hct_pkg::beat_type           beat,
   output logic                        beat_valid
);
   import hct_pkg::*;

   req_type    cell_ff, cell_in;
   logic       cell_vld_ff, cell_vld_in;
   logic [2:0] slot_ff, slot_in;
   beat_type   beat_ff, beat_in;
   logic       beat_vld_ff, beat_vld_in;
   logic       accept;
   logic       finishing;

   logic [1:0] parity;
   logic [2:0] base;
   logic [1:0] cn, t0, t1, t2;
   logic [HGT_W-1:0] h0, h1, h2;
   logic signed [2:0]  a1, c1, a2, c2;
   logic signed [9:0]  b1, b2;
   logic signed [12:0] pr0, pr1, qr0, qr1, rr0, rr1;

   function automatic logic [HGT_W-1:0] corner_height(input req_type c,
                                                       input logic [1:0] k);
      logic [HGT_W-1:0] h;
      h = c.height_near_left;
      case (k)
         2'd0:    h = c.height_near_left;
         2'd1:    h = c.height_near_right;
         2'd2:    h = c.height_far_left;
         2'd3:    h = c.height_far_right;
         default: h = c.height_near_left;
      endcase
      return h;
   endfunction

   // The cell is released as its sixth vertex moves on.
   assign finishing = cell_vld_ff && adv && (slot_ff == SLOT_LAST);
   assign req_stall = cell_vld_ff && !finishing;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cell_in     = cell_ff;
      cell_vld_in = cell_vld_ff;
      slot_in     = slot_ff;
      if (cell_vld_ff && adv) begin
         if (slot_ff == SLOT_LAST) begin
            cell_vld_in = 1'b0;
         end else begin
            slot_in = slot_ff + 3'd1;
         end
      end
      if (accept) begin
         cell_in     = req_data;
         cell_vld_in = 1'b1;
         slot_in     = 3'd0;
      end
   end

   // Corners of the vertex and of its triangle.
   assign parity = {cell_ff.cell_row[0], cell_ff.cell_column[0]};
   assign base   = (slot_ff >= 3'd3) ? 3'd3 : 3'd0;
   assign cn     = slot_corner(parity, slot_ff);
   assign t0     = slot_corner(parity, base);
   assign t1     = slot_corner(parity, base + 3'd1);
   assign t2     = slot_corner(parity, base + 3'd2);
   assign h0     = corner_height(cell_ff, t0);
   assign h1     = corner_height(cell_ff, t1);
   assign h2     = corner_height(cell_ff, t2);

   // Edge vectors in grid units and their cross product.
   assign a1 = $signed({2'b00, t1[0]}) - $signed({2'b00, t0[0]});
   assign c1 = $signed({2'b00, t1[1]}) - $signed({2'b00, t0[1]});
   assign a2 = $signed({2'b00, t2[0]}) - $signed({2'b00, t0[0]});
   assign c2 = $signed({2'b00, t2[1]}) - $signed({2'b00, t0[1]});
   assign b1 = $signed({2'b00, h1}) - $signed({2'b00, h0});
   assign b2 = $signed({2'b00, h2}) - $signed({2'b00, h0});
   assign pr0 = b1 * c2;
   assign pr1 = c1 * b2;
   assign qr0 = c1 * a2;
   assign qr1 = a1 * c2;
   assign rr0 = a1 * b2;
   assign rr1 = b1 * a2;

   always_comb begin
      beat_in.vc   = {1'b0, cell_ff.cell_column} + {{(GRID_W-1){1'b0}}, cn[0]};
      beat_in.vr   = {1'b0, cell_ff.cell_row} + {{(GRID_W-1){1'b0}}, cn[1]};
      beat_in.dx   = $signed({2'b00, beat_in.vc, 4'b0000})
                     - $signed({3'b000, grid_width, 3'b000});
      beat_in.dz   = $signed({2'b00, beat_in.vr, 4'b0000})
                     - $signed({3'b000, grid_height, 3'b000});
      beat_in.h    = corner_height(cell_ff, cn);
      beat_in.p    = CROSS_W'(pr0 - pr1);
      beat_in.q    = CROSS_W'(qr0 - qr1);
      beat_in.r    = CROSS_W'(rr0 - rr1);
      beat_in.last = (slot_ff == SLOT_LAST);
      beat_vld_in  = adv ? cell_vld_ff : beat_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff <= 1'b0;
         slot_ff     <= 3'd0;
         beat_vld_ff <= 1'b0;
      end else begin
         cell_vld_ff <= cell_vld_in;
         slot_ff     <= slot_in;
         beat_vld_ff <= beat_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (adv) begin
         beat_ff <= beat_in;
      end
   end

   assign beat       = beat_ff;
   assign beat_valid = beat_vld_ff;

endmodule

`default_nettype wire

[rtl/core/hct_sqrt.sv]
`default_nettype none

// Pipelined integer square root, two result bits per stage.
module hct_sqrt (
   input  wire                         clock,
   input  wire                         adv,
   input  wire [hct_pkg::SUM_W-1:0]    radicand,
   output logic [hct_pkg::LEN_W-1:0]   root
);
   import hct_pkg::*;

   localparam int RAD_W = 2 * LEN_W;

   sq_type           st_ff  [SQ_STAGES];
   logic [RAD_W-1:0] rad_ff [SQ_STAGES];

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
      sq_type           st_in;
      logic [RAD_W-1:0] rad_in;
      sq_type           prev;
      logic [RAD_W-1:0] rad_prev;

      if (k == 0) begin : g_first
         assign prev     = '0;
         assign rad_prev = RAD_W'(radicand);
      end else begin : g_next
         assign prev     = st_ff[k-1];
         assign rad_prev = rad_ff[k-1];
      end

      // Consume the top bit pairs of what is left of the radicand.
      assign st_in  = sqrt_step(prev, rad_prev[RAD_W-1 -: 2*SQ_PER_STAGE]);
      assign rad_in = {rad_prev[RAD_W-2*SQ_PER_STAGE-1:0], {(2*SQ_PER_STAGE){1'b0}}};

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k]  <= st_in;
            rad_ff[k] <= rad_in;
         end
      end
   end

   assign root = st_ff[SQ_STAGES-1].root;

endmodule

`default_nettype wire

[rtl/core/hct_div.sv]
`default_nettype none

// Three lanes of pipelined rounded division: (16384 * mag + len / 2) / len.
module hct_div (
   input  wire                                 clock,
   input  wire                                 adv,
   input  wire [2:0][hct_pkg::MAG_W-1:0]       mag,
   input  wire [hct_pkg::LEN_W-1:0]            len,
   output logic [2:0][hct_pkg::QUO_W-1:0]      quo
);
   import hct_pkg::*;

   localparam int DIVD_W = MAG_W + 15;

   logic [LEN_W-1:0]             len_ff [DIV_STAGES];
   logic [2:0][DREM_W-1:0]       rem_ff [DIV_STAGES];
   logic [2:0][QUO_W-1:0]        low_ff [DIV_STAGES];
   logic [2:0][QUO_W-1:0]        quo_ff [DIV_STAGES];

   // Set-up stage: form the rounded dividend and split it.
   logic [2:0][DREM_W-1:0] rem_init;
   logic [2:0][QUO_W-1:0]  low_init;
   logic [DIVD_W-1:0]      divd [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         divd[j]     = {1'b0, mag[j], 14'd0} + DIVD_W'(len >> 1);
         rem_init[j] = DREM_W'(divd[j][DIVD_W-1:QUO_W]);
         low_init[j] = divd[j][QUO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len_ff[0] <= len;
         rem_ff[0] <= rem_init;
         low_ff[0] <= low_init;
         quo_ff[0] <= '0;
      end
   end

   // Restoring steps, three quotient bits per stage.
   for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
      logic [2:0][DREM_W-1:0] rem_in;
      logic [2:0][QUO_W-1:0]  low_in;
      logic [2:0][QUO_W-1:0]  quo_in;
      logic [DREM_W:0]        t;

      always_comb begin
         rem_in = rem_ff[k-1];
         low_in = low_ff[k-1];
         quo_in = quo_ff[k-1];
         t      = '0;
         for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < DIV_PER_STAGE; i++) begin
               t         = {rem_in[j], low_in[j][QUO_W-1]};
               low_in[j] = {low_in[j][QUO_W-2:0], 1'b0};
               if (t >= {1'b0, len_ff[k-1]}) begin
                  rem_in[j] = DREM_W'(t - {1'b0, len_ff[k-1]});
                  quo_in[j] = {quo_in[j][QUO_W-2:0], 1'b1};
               end else begin
                  rem_in[j] = t[DREM_W-1:0];
                  quo_in[j] = {quo_in[j][QUO_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            len_ff[k] <= len_ff[k-1];
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_in;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

`default_nettype wire
